// File: rtl/core/lboc_pkg.sv
// character classes and the kinsoku flag table for the line break check
package lboc_pkg;

  localparam int CharWidth = 16;
  localparam int DistWidth = 2;

  typedef logic [CharWidth-1:0] char_t;
  typedef logic [DistWidth-1:0] dist_t;

  typedef struct packed {
    logic no_end;
    logic no_begin;
  } kin_flags_t;

  localparam char_t ChTab        = 16'h0009;
  localparam char_t ChCr         = 16'h000D;
  localparam char_t ChSpace      = 16'h0020;
  localparam char_t ChQuote      = 16'h0022;
  localparam char_t ChHyphen     = 16'h002D;
  localparam char_t ChIdeoSpace  = 16'h3000;

  localparam char_t EaJamoLo     = 16'h1100;
  localparam char_t EaJamoHi     = 16'h11FF;
  localparam char_t EaCjkLo      = 16'h3000;
  localparam char_t EaCjkHi      = 16'hD7AF;
  localparam char_t EaCompatLo   = 16'hF900;
  localparam char_t EaCompatHi   = 16'hFAFF;
  localparam char_t EaFullLo     = 16'hFF00;
  localparam char_t EaFullHi     = 16'hFFDC;

  localparam dist_t DistStart    = 2'd0;

  function automatic logic is_space(input char_t c);
    return (c == ChTab) || (c == ChCr) || (c == ChSpace) || (c == ChIdeoSpace);
  endfunction

  function automatic logic is_east_asian(input char_t c);
    return ((c >= EaJamoLo) && (c <= EaJamoHi)) ||
           ((c >= EaCjkLo) && (c <= EaCjkHi)) ||
           ((c >= EaCompatLo) && (c <= EaCompatHi)) ||
           ((c >= EaFullLo) && (c <= EaFullHi));
  endfunction

  // exact match against the kinsoku table
  function automatic kin_flags_t kin_flags(input char_t c);
    kin_flags_t f;
    f = '0;
    unique case (c)
      16'h0021, 16'h0025, 16'h0029, 16'h002E, 16'h003A, 16'h003B, 16'h003F,
      16'h005D, 16'h007D, 16'h00A2, 16'h00A8, 16'h00A9, 16'h00AE, 16'h00B0,
      16'h00B7, 16'h02C7, 16'h02C9, 16'h2013, 16'h2014, 16'h2015, 16'h2016,
      16'h2019, 16'h201D, 16'h2025, 16'h2026, 16'h2027, 16'h2032, 16'h2033,
      16'h2103, 16'h2122, 16'h2236, 16'h2574, 16'h3001, 16'h3002, 16'h3003,
      16'h3005, 16'h3009, 16'h300B, 16'h300D, 16'h300F, 16'h3011, 16'h3015,
      16'h3017, 16'h301E, 16'h301F, 16'h3041, 16'h3043, 16'h3045, 16'h3047,
      16'h3049, 16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h308E, 16'h3099,
      16'h309A, 16'h309B, 16'h309C, 16'h309D, 16'h309E, 16'h30A1, 16'h30A3,
      16'h30A5, 16'h30A7, 16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7,
      16'h30EE, 16'h30F5, 16'h30F6, 16'h30FB, 16'h30FC, 16'h30FD, 16'h30FE,
      16'hFE50, 16'hFE51, 16'hFE52, 16'hFE54, 16'hFE55, 16'hFE56, 16'hFE57,
      16'hFE5A, 16'hFE5C, 16'hFE5E, 16'hFF01, 16'hFF02, 16'hFF05, 16'hFF07,
      16'hFF09, 16'hFF0C, 16'hFF0E, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF3D,
      16'hFF40, 16'hFF5C, 16'hFF5D, 16'hFF5E: begin
        f.no_begin = 1'b1;
      end
      16'h0024, 16'h0028, 16'h005B, 16'h005C, 16'h007B, 16'h00A3, 16'h00A5,
      16'h00A7, 16'h2018, 16'h201C, 16'h2035, 16'h266F, 16'h3008, 16'h300A,
      16'h300C, 16'h300E, 16'h3010, 16'h3012, 16'h3014, 16'h3016, 16'h301D,
      16'hFE59, 16'hFE5B, 16'hFE5D, 16'hFF04, 16'hFF08, 16'hFF20, 16'hFF3B,
      16'hFF5B, 16'hFFE1, 16'hFFE5, 16'hFFE6: begin
        f.no_end = 1'b1;
      end
      16'h0027, 16'h002F, 16'hFFE0: begin
        f.no_begin = 1'b1;
        f.no_end   = 1'b1;
      end
      default: begin
        f = '0;
      end
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/line_break_opportunity_check.sv
// line break opportunity check: kinsoku and quote rules over a four character window
// One character window is accepted per cycle while in_stall is low; each request passes
// through two registers: the window is captured in an input register, the rules and three
// lookups in the flag table run in one combinational pass, and the decision lands in a
// result register. in_stall rises only when both registers are full and out_stall is high,
// so a sustained stream runs at one item per cycle. The block holds no state between items.
module line_break_opportunity_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lboc_pkg::char_t      cur_char,
  input  lboc_pkg::char_t      prev_char,
  input  lboc_pkg::char_t      prev2_char,
  input  lboc_pkg::char_t      next_char,
  input  lboc_pkg::dist_t      dist_from_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 can_break
);

  logic            s1_valid;
  lboc_pkg::char_t s1_cur;
  lboc_pkg::char_t s1_prev;
  lboc_pkg::char_t s1_prev2;
  lboc_pkg::char_t s1_next;
  lboc_pkg::dist_t s1_dist;

  logic s1_adv;
  logic in_take;
  logic can_break_next;

  lboc_pkg::kin_flags_t cur_flags;
  lboc_pkg::kin_flags_t prev_flags;
  lboc_pkg::kin_flags_t next_flags;
  logic cur_sp, prev_sp, prev2_sp, next_sp;
  logic soft_spot;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    cur_flags  = lboc_pkg::kin_flags(s1_cur);
    prev_flags = lboc_pkg::kin_flags(s1_prev);
    next_flags = lboc_pkg::kin_flags(s1_next);
    cur_sp     = lboc_pkg::is_space(s1_cur);
    prev_sp    = lboc_pkg::is_space(s1_prev);
    prev2_sp   = lboc_pkg::is_space(s1_prev2);
    next_sp    = lboc_pkg::is_space(s1_next);
    soft_spot  = cur_sp || lboc_pkg::is_east_asian(s1_cur) ||
                 lboc_pkg::is_east_asian(s1_prev) || (s1_prev == lboc_pkg::ChHyphen);
    priority if (s1_dist == lboc_pkg::DistStart) begin
      can_break_next = 1'b0;
    end else if (cur_sp && next_flags.no_begin) begin
      can_break_next = 1'b0;
    end else if (s1_dist[1] && prev2_sp && (s1_prev == lboc_pkg::ChQuote) && !cur_sp) begin
      // opening quote left dangling
      can_break_next = 1'b0;
    end else if (!prev_sp && (s1_cur == lboc_pkg::ChQuote) && next_sp) begin
      // closing quote pushed down
      can_break_next = 1'b0;
    end else begin
      can_break_next = soft_spot && !cur_flags.no_begin && !prev_flags.no_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
    if (in_take) begin
      s1_cur   <= cur_char;
      s1_prev  <= prev_char;
      s1_prev2 <= prev2_char;
      s1_next  <= next_char;
      s1_dist  <= dist_from_start;
    end
    if (s1_adv && s1_valid) begin
      can_break <= can_break_next;
    end
  end

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with an empty pipeline");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted request lost in input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_cur) && $stable(s1_next)))
    else $error("held request changed in input register");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && (s1_dist == lboc_pkg::DistStart)) |=> (out_valid && !can_break))
    else $error("break allowed at line start");

  a_move_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> out_valid)
    else $error("request dropped between stages");
`endif

endmodule
